// File: hdl/md4_pkg.sv
`timescale 1ns / 1ps

package md4_pkg;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam logic [3:0][31:0] IvInit = {IvD, IvC, IvB, IvA};

  localparam logic [31:0] KeyG = 32'h5a827999;
  localparam logic [31:0] KeyH = 32'h6ed9eba1;

  localparam logic [5:0] RoundLast  = 6'd47;
  localparam logic [6:0] PadStop    = 7'd56;
  localparam logic [6:0] BlockBytes = 7'd64;
  localparam logic [5:0] PosLast    = 6'd63;
  localparam logic [7:0] PadMarker  = 8'h80;
  localparam logic [1:0] WordLast   = 2'd3;

  localparam logic [1:0] StageF = 2'd0;
  localparam logic [1:0] StageG = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } md4_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
  } md4_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_LEN,
    ST_START,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } md4_state_e;

  typedef struct packed {
    logic take_byte;
    logic pad_mark;
    logic pad_zero;
    logic ptr_clear;
    logic write_len;
    logic rw_load;
    logic round_step;
    logic chain_add;
    logic out_next;
  } md4_cmd_t;

  typedef struct packed {
    logic pos_full;
    logic ptr_at_stop;
    logic ptr_at_end;
    logic round_last;
    logic out_last;
  } md4_stat_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

  // block word used by a round: straight, column order, bit-reversed order
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] j;
    j = r[3:0];
    case (r[5:4])
      StageF:  return j;
      StageG:  return {j[1:0], j[3:2]};
      default: return {j[0], j[1], j[2], j[3]};
    endcase
  endfunction

  function automatic logic [4:0] round_shift(input logic [5:0] r);
    case ({r[5:4], r[1:0]})
      4'b00_00: return 5'd3;
      4'b00_01: return 5'd7;
      4'b00_10: return 5'd11;
      4'b00_11: return 5'd19;
      4'b01_00: return 5'd3;
      4'b01_01: return 5'd5;
      4'b01_10: return 5'd9;
      4'b01_11: return 5'd13;
      4'b10_00: return 5'd3;
      4'b10_01: return 5'd9;
      4'b10_10: return 5'd11;
      default:  return 5'd15;
    endcase
  endfunction

  function automatic logic [31:0] round_fn(input logic [5:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    case (r[5:4])
      StageF:  return (b & c) | (~b & d);
      StageG:  return ((b & c) | (b & d) | (c & d)) + KeyG;
      default: return (b ^ c ^ d) + KeyH;
    endcase
  endfunction

endpackage

// File: hdl/md4_datapath.sv
`timescale 1ns / 1ps

module md4_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md4_pkg::md4_cmd_t cmd_i,
  input  logic [7:0]        data_byte_i,
  output md4_pkg::md4_stat_t stat_o,
  output md4_pkg::md4_out_t out_word_o
);
  import md4_pkg::*;

  logic [3:0][31:0] chain_q;
  logic [31:0]      block_q [16];
  logic [60:0]      count_q;
  logic [6:0]       ptr_q;
  logic [31:0]      a_q, b_q, c_q, d_q;
  logic [5:0]       round_q;
  logic [1:0]       k_q;

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_val;
  logic [63:0] bit_len;
  logic [31:0] step_sum;
  logic [31:0] step_new;
  logic        restart;

  assign bit_len  = {count_q, 3'b000};
  assign restart  = cmd_i.out_next && (k_q == WordLast);
  assign step_sum = a_q + round_fn(round_q, b_q, c_q, d_q) + block_q[msg_index(round_q)];
  assign step_new = rotl32(step_sum, round_shift(round_q));

  always_comb begin
    wr_en  = cmd_i.take_byte || cmd_i.pad_mark || cmd_i.pad_zero;
    wr_pos = count_q[5:0];
    wr_val = data_byte_i;
    if (cmd_i.pad_mark) begin
      wr_val = PadMarker;
    end else if (cmd_i.pad_zero) begin
      wr_pos = ptr_q[5:0];
      wr_val = 8'h00;
    end
  end

  // block buffer: no reset, every byte is written before a block is hashed
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      block_q[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_val;
    end
    if (cmd_i.write_len) begin
      block_q[14] <= bit_len[31:0];
      block_q[15] <= bit_len[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= IvInit;
      count_q <= '0;
      ptr_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      c_q     <= '0;
      d_q     <= '0;
      round_q <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.take_byte) begin
        count_q <= count_q + 61'd1;
      end else if (restart) begin
        count_q <= '0;
      end

      if (cmd_i.pad_mark) begin
        ptr_q <= {1'b0, count_q[5:0]} + 7'd1;
      end else if (cmd_i.pad_zero) begin
        ptr_q <= ptr_q + 7'd1;
      end else if (cmd_i.ptr_clear) begin
        ptr_q <= '0;
      end

      if (cmd_i.rw_load) begin
        a_q     <= chain_q[0];
        b_q     <= chain_q[1];
        c_q     <= chain_q[2];
        d_q     <= chain_q[3];
        round_q <= '0;
      end else if (cmd_i.round_step) begin
        // rotate the working words so the target is always in a_q
        a_q     <= d_q;
        b_q     <= step_new;
        c_q     <= b_q;
        d_q     <= c_q;
        round_q <= round_q + 6'd1;
      end

      if (cmd_i.chain_add) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
      end else if (restart) begin
        chain_q <= IvInit;
      end

      if (cmd_i.out_next) begin
        k_q <= k_q + 2'd1;
      end
    end
  end

  assign stat_o.pos_full    = (count_q[5:0] == PosLast);
  assign stat_o.ptr_at_stop = (ptr_q == PadStop);
  assign stat_o.ptr_at_end  = (ptr_q == BlockBytes);
  assign stat_o.round_last  = (round_q == RoundLast);
  assign stat_o.out_last    = (k_q == WordLast);

  assign out_word_o.digest_word = chain_q[k_q];
  assign out_word_o.word_index  = k_q;
  assign out_word_o.digest_last = (k_q == WordLast);

  a_pad_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pad_zero |-> (ptr_q < BlockBytes))
    else $error("zero pad written past end of block");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round_step |-> (round_q <= RoundLast))
    else $error("round counter ran past last round");

endmodule

// File: hdl/md4_ctrl.sv
`timescale 1ns / 1ps

module md4_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               byte_valid_i,
  input  logic               last_byte_i,
  input  logic               out_stall_i,
  input  md4_pkg::md4_stat_t stat_i,
  output md4_pkg::md4_cmd_t  cmd_o,
  output logic               in_stall_o,
  output logic               out_valid_o
);
  import md4_pkg::*;

  md4_state_e state_q, state_d;
  md4_state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // next state; ret_q holds where to go once a compression is done
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (byte_valid_i && stat_i.pos_full) begin
            state_d = ST_START;
            ret_d   = last_byte_i ? ST_PAD_MARK : ST_IDLE;
          end else if (last_byte_i) begin
            state_d = ST_PAD_MARK;
          end
        end
      end
      ST_PAD_MARK: state_d = ST_PAD_ZERO;
      ST_PAD_ZERO: begin
        if (stat_i.ptr_at_stop) begin
          state_d = ST_LEN;
        end else if (stat_i.ptr_at_end) begin
          state_d = ST_START;
          ret_d   = ST_PAD_ZERO;
        end
      end
      ST_LEN: begin
        state_d = ST_START;
        ret_d   = ST_OUT;
      end
      ST_START: state_d = ST_ROUND;
      ST_ROUND: begin
        if (stat_i.round_last) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: state_d = ret_q;
      ST_OUT: begin
        if (!out_stall_i && stat_i.out_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.take_byte = in_valid_i && byte_valid_i;
      end
      ST_PAD_MARK: cmd_o.pad_mark = 1'b1;
      ST_PAD_ZERO: begin
        cmd_o.pad_zero  = !stat_i.ptr_at_stop && !stat_i.ptr_at_end;
        cmd_o.ptr_clear = stat_i.ptr_at_end;
      end
      ST_LEN:   cmd_o.write_len  = 1'b1;
      ST_START: cmd_o.rw_load    = 1'b1;
      ST_ROUND: cmd_o.round_step = 1'b1;
      ST_ADD:   cmd_o.chain_add  = 1'b1;
      ST_OUT: begin
        out_valid_o    = 1'b1;
        cmd_o.out_next = !out_stall_i;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: hdl/md4_hash_engine.sv
`timescale 1ns / 1ps
// Throughput: one byte word per cycle while a block gathers; every 64th byte stalls the input
//   for a compression (load, 48 single-round steps on one round unit, chain add).
// After the last byte: a pad marker, zero pad bytes to byte 56, the length words and a compression;
//   a spill into a second block adds a compression, as does a last byte that fills a block.
// Reset: chaining words go to the MD4 initial values, byte count and control clear;
//   the block buffer is not reset.
module md4_hash_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  md4_pkg::md4_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output md4_pkg::md4_out_t out_word_o
);
  import md4_pkg::*;

  md4_cmd_t  cmd;
  md4_stat_t stat;

  md4_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .byte_valid_i (in_word_i.byte_valid),
    .last_byte_i  (in_word_i.last_byte),
    .out_stall_i  (out_stall_i),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o)
  );

  md4_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (in_word_i.data_byte),
    .stat_o      (stat),
    .out_word_o  (out_word_o)
  );

  a_no_input_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while digest is emitted");

  a_index_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_word_o.digest_last) |=>
      (out_valid_o && (out_word_o.word_index == $past(out_word_o.word_index) + 2'd1)))
    else $error("digest words not sent in order");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.digest_last == (out_word_o.word_index == WordLast)))
    else $error("digest_last does not match word index");

endmodule
